// ----- sv/ncps_pkg.sv -----
package ncps_pkg;

  // default sample width of the spectrum bins
  localparam int SAMPLE_WIDTH_DEF = 16;
  // magnitudes are brought below 2^NORM_BITS before squaring
  localparam int NORM_BITS = 30;
  // result width and quotient bits (result magnitude is at most 2^14)
  localparam int OUT_W  = 16;
  localparam int Q_BITS = 15;
  // stage counts of the square root and divider pipelines
  localparam int ROOT_STAGES = NORM_BITS + 1;
  localparam int DIV_STAGES  = Q_BITS + 1;

  // per-bin flags that travel with the data
  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic zero;
    logic frame_end;
  } ncps_flags_t;

  // flags plus the normalized part magnitudes
  typedef struct packed {
    ncps_flags_t            flags;
    logic [NORM_BITS-1:0]   mag_re;
    logic [NORM_BITS-1:0]   mag_im;
  } ncps_side_t;

endpackage

// ----- sv/ncps_in_if.sv -----
interface ncps_in_if
  import ncps_pkg::*;
#(
  parameter int W = SAMPLE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_re;
  logic signed [W-1:0] first_im;
  logic signed [W-1:0] second_re;
  logic signed [W-1:0] second_im;
  logic                frame_end;

  modport source (
    output valid, first_re, first_im, second_re, second_im, frame_end,
    input  ready
  );
  modport sink (
    input  valid, first_re, first_im, second_re, second_im, frame_end,
    output ready
  );
endinterface

// ----- sv/ncps_out_if.sv -----
interface ncps_out_if
  import ncps_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_re;
  logic signed [OUT_W-1:0] out_im;
  logic                    zero_magnitude;
  logic                    frame_end_out;

  modport source (
    output valid, out_re, out_im, zero_magnitude, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, out_re, out_im, zero_magnitude, frame_end_out,
    output ready
  );
endinterface

// ----- sv/ncps_isqrt.sv -----
module ncps_isqrt
  import ncps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*NORM_BITS:0] radicand,
  input  ncps_side_t           in_side,
  output logic                 out_valid,
  output logic [NORM_BITS:0]   root,
  output ncps_side_t           out_side
);

  localparam int RW = 2 * NORM_BITS + 2;

  logic [RW-1:0] rem_r  [ROOT_STAGES];
  logic [RW-1:0] res_r  [ROOT_STAGES];
  logic          v      [ROOT_STAGES];
  ncps_side_t    side_r [ROOT_STAGES];

  // one result bit per stage, most significant first
  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    localparam logic [RW-1:0] BIT_C = RW'(1) << (2 * (NORM_BITS - s));
    logic [RW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic          v_in;
    ncps_side_t    side_in;
    logic [RW-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(radicand);
      assign res_in  = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign res_in  = res_r[s-1];
      assign v_in    = v[s-1];
      assign side_in = side_r[s-1];
    end

    assign trial = res_in + BIT_C;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          res_r[s] <= (res_in >> 1) + BIT_C;
        end else begin
          rem_r[s] <= rem_in;
          res_r[s] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = v[ROOT_STAGES-1];
  assign root      = res_r[ROOT_STAGES-1][NORM_BITS:0];
  assign out_side  = side_r[ROOT_STAGES-1];

endmodule

// ----- sv/ncps_div.sv -----
module ncps_div
  import ncps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NORM_BITS:0] root,
  input  ncps_side_t         in_side,
  output logic               out_valid,
  output logic [Q_BITS-1:0]  q_re,
  output logic [Q_BITS-1:0]  q_im,
  output ncps_flags_t        out_flags
);

  localparam int NW = NORM_BITS + Q_BITS + 1;
  localparam int DW = NORM_BITS + 2;

  // prep stage: numerator = mag * 2^15 + root, divisor = 2 * root
  logic [NW-1:0] num_re0;
  logic [NW-1:0] num_im0;
  logic [DW-1:0] den0;
  logic          v0;
  ncps_flags_t   flags0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_re0 <= {1'b0, in_side.mag_re, {Q_BITS{1'b0}}} + NW'(root);
      num_im0 <= {1'b0, in_side.mag_im, {Q_BITS{1'b0}}} + NW'(root);
      den0    <= {root, 1'b0};
      flags0  <= in_side.flags;
    end
  end

  logic [NW-1:0]     rem_re [Q_BITS];
  logic [NW-1:0]     rem_im [Q_BITS];
  logic [Q_BITS-1:0] quo_re [Q_BITS];
  logic [Q_BITS-1:0] quo_im [Q_BITS];
  logic [DW-1:0]     den    [Q_BITS];
  logic              v      [Q_BITS];
  ncps_flags_t       flags  [Q_BITS];

  // restoring division, one quotient bit per stage for both parts
  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    localparam int J = Q_BITS - 1 - s;
    logic [NW-1:0]     r_re_in;
    logic [NW-1:0]     r_im_in;
    logic [Q_BITS-1:0] q_re_in;
    logic [Q_BITS-1:0] q_im_in;
    logic [DW-1:0]     d_in;
    logic              v_in;
    ncps_flags_t       f_in;
    logic [NW-1:0]     d_sh;

    if (s == 0) begin : g_first
      assign r_re_in = num_re0;
      assign r_im_in = num_im0;
      assign q_re_in = '0;
      assign q_im_in = '0;
      assign d_in    = den0;
      assign v_in    = v0;
      assign f_in    = flags0;
    end else begin : g_next
      assign r_re_in = rem_re[s-1];
      assign r_im_in = rem_im[s-1];
      assign q_re_in = quo_re[s-1];
      assign q_im_in = quo_im[s-1];
      assign d_in    = den[s-1];
      assign v_in    = v[s-1];
      assign f_in    = flags[s-1];
    end

    assign d_sh = NW'(d_in) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[s]   <= d_in;
        flags[s] <= f_in;
        if (r_re_in >= d_sh) begin
          rem_re[s] <= r_re_in - d_sh;
          quo_re[s] <= q_re_in | (Q_BITS'(1) << J);
        end else begin
          rem_re[s] <= r_re_in;
          quo_re[s] <= q_re_in;
        end
        if (r_im_in >= d_sh) begin
          rem_im[s] <= r_im_in - d_sh;
          quo_im[s] <= q_im_in | (Q_BITS'(1) << J);
        end else begin
          rem_im[s] <= r_im_in;
          quo_im[s] <= q_im_in;
        end
      end
    end
  end

  assign out_valid = v[Q_BITS-1];
  assign q_re      = quo_re[Q_BITS-1];
  assign q_im      = quo_im[Q_BITS-1];
  assign out_flags = flags[Q_BITS-1];

endmodule

// ----- sv/normalized_cross_power_spectrum.sv -----
// the pipeline holds 6 front stages, 31 square root stages, 16 divider
// stages and 1 output register between input transaction and result
// throughput: one bin per cycle; the whole pipeline advances together and
// holds while a finished result waits on a low ready
// reset: synchronous active-high rst clears all valid bits, data is not reset
module normalized_cross_power_spectrum
  import ncps_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ncps_in_if.sink    samples,
  ncps_out_if.source result
);

  localparam int MAG_W = 2 * SAMPLE_WIDTH;
  localparam int MAGX  = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
  localparam int KW    = $clog2(MAGX + 1);
  localparam int SQ_W  = 2 * NORM_BITS;

  logic adv;

  // pipeline moves whenever the output register is free or being taken
  assign adv           = !result.valid || result.ready;
  assign samples.ready = adv;

  // stage 1: complex product
  logic signed [MAG_W:0] ac, bd, ad, bc;
  logic signed [MAG_W:0] re1, im1;
  logic                  v1, fe1;

  assign ac = (MAG_W+1)'(samples.first_re * samples.second_re);
  assign bd = (MAG_W+1)'(samples.first_im * samples.second_im);
  assign ad = (MAG_W+1)'(samples.first_re * samples.second_im);
  assign bc = (MAG_W+1)'(samples.first_im * samples.second_re);

  always_ff @(posedge clk) begin
    if (adv) begin
      re1 <= ac - bd;
      im1 <= ad + bc;
      fe1 <= samples.frame_end;
    end
  end

  // stage 2: magnitudes, signs and zero detect
  logic [MAG_W:0]  abs_re1, abs_im1;
  logic [MAGX-1:0] mag_re2, mag_im2;
  ncps_flags_t     flags2;
  logic            v2;

  assign abs_re1 = re1[MAG_W] ? -re1 : re1;
  assign abs_im1 = im1[MAG_W] ? -im1 : im1;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_re2          <= MAGX'(abs_re1[MAG_W-1:0]);
      mag_im2          <= MAGX'(abs_im1[MAG_W-1:0]);
      flags2.neg_re    <= re1[MAG_W];
      flags2.neg_im    <= im1[MAG_W];
      flags2.zero      <= (re1 == '0) && (im1 == '0);
      flags2.frame_end <= fe1;
    end
  end

  // stage 3: shift count that brings both magnitudes below 2^30
  logic [MAGX-1:0] mag_or2;
  logic [KW-1:0]   k_next;
  logic [KW-1:0]   k3;
  logic [MAGX-1:0] mag_re3, mag_im3;
  ncps_flags_t     flags3;
  logic            v3;

  assign mag_or2 = mag_re2 | mag_im2;

  always_comb begin
    k_next = '0;
    for (int b = NORM_BITS; b < MAGX; b++) begin
      if (mag_or2[b]) begin
        k_next = KW'(b - NORM_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k3      <= k_next;
      mag_re3 <= mag_re2;
      mag_im3 <= mag_im2;
      flags3  <= flags2;
    end
  end

  // stage 4: normalizing shift
  logic [MAGX-1:0] sh_re3, sh_im3;
  ncps_side_t      side4;
  logic            v4;

  assign sh_re3 = mag_re3 >> k3;
  assign sh_im3 = mag_im3 >> k3;

  always_ff @(posedge clk) begin
    if (adv) begin
      side4.mag_re <= sh_re3[NORM_BITS-1:0];
      side4.mag_im <= sh_im3[NORM_BITS-1:0];
      side4.flags  <= flags3;
    end
  end

  // stage 5: squares
  logic [SQ_W-1:0] sq_re5, sq_im5;
  ncps_side_t      side5;
  logic            v5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_re5 <= SQ_W'(side4.mag_re * side4.mag_re);
      sq_im5 <= SQ_W'(side4.mag_im * side4.mag_im);
      side5  <= side4;
    end
  end

  // stage 6: sum of squares
  logic [SQ_W:0] sum6;
  ncps_side_t    side6;
  logic          v6;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum6  <= (SQ_W+1)'(sq_re5) + (SQ_W+1)'(sq_im5);
      side6 <= side5;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // magnitude by integer square root
  logic               root_valid;
  logic [NORM_BITS:0] root;
  ncps_side_t         root_side;

  ncps_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .radicand  (sum6),
    .in_side   (side6),
    .out_valid (root_valid),
    .root      (root),
    .out_side  (root_side)
  );

  // rounded division of each part by the magnitude
  logic              div_valid;
  logic [Q_BITS-1:0] q_re, q_im;
  ncps_flags_t       div_flags;

  ncps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (root_valid),
    .root      (root),
    .in_side   (root_side),
    .out_valid (div_valid),
    .q_re      (q_re),
    .q_im      (q_im),
    .out_flags (div_flags)
  );

  // output register: signs and zero forcing
  logic [OUT_W-1:0] pos_re, pos_im;

  assign pos_re = OUT_W'(q_re);
  assign pos_im = OUT_W'(q_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (div_flags.zero) begin
        result.out_re <= '0;
        result.out_im <= '0;
      end else begin
        result.out_re <= div_flags.neg_re ? -pos_re : pos_re;
        result.out_im <= div_flags.neg_im ? -pos_im : pos_im;
      end
      result.zero_magnitude <= div_flags.zero;
      result.frame_end_out  <= div_flags.frame_end;
    end
  end

endmodule
